// ----- src/dsnf_pkg.sv -----
// shared types, codes and constants for the 8.3 short name formatter
`default_nettype none

package dsnf_pkg;

  localparam int unsigned BaseLen = 8;
  localparam int unsigned ExtLen  = 3;
  localparam int unsigned NameLen = BaseLen + ExtLen;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot   = 8'h2e;

  typedef enum logic [1:0] {
    PH_BASE,
    PH_SKIP,
    PH_SDOT,
    PH_EXT
  } phase_t;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_RELAXED,
    MODE_STRICT,
    MODE_STRICT_REPL
  } mode_t;

  typedef enum logic [1:0] {
    ST_VALID,
    ST_INVALID,
    ST_DOT_DENIED
  } status_t;

  typedef enum logic {
    REG_CHECK_MODE,
    REG_ALLOW_DOT_DIRS
  } reg_idx_t;

  typedef struct packed {
    mode_t check_mode;
    logic  allow_dot_dirs;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [8*BaseLen-1:0] base_field;
    logic [8*ExtLen-1:0]  ext_field;
  } result_t;

endpackage

`default_nettype wire

// ----- src/dsnf_in_if.sv -----
// input channel: one name character per transaction
`default_nettype none

interface dsnf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       name_empty;

  modport source (output valid, char_code, last_char, name_empty, input ready);
  modport sink   (input valid, char_code, last_char, name_empty, output ready);
endinterface

`default_nettype wire

// ----- src/dsnf_out_if.sv -----
// result channel: status and formatted 8.3 fields
`default_nettype none

interface dsnf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] base_field;
  logic [23:0] ext_field;

  modport source (output valid, status, base_field, ext_field, input ready);
  modport sink   (input valid, status, base_field, ext_field, output ready);
endinterface

`default_nettype wire

// ----- src/dsnf_cfg_if.sv -----
// configuration write channel
`default_nettype none

interface dsnf_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/dos_short_name_formatter.sv -----
// top level of the 8.3 short name formatter
//
//   channel | dir | payload                                  | transaction
//   in_if   | in  | char_code, last_char, name_empty         | one name character
//   out_if  | out | status, base_field, ext_field            | one finished name
//   cfg_if  | in  | index, data                              | one register write
//
// one character per cycle when ready; a result is offered from the output register
// the cycle after the transaction carrying the last character or an empty-name flag
// name state updates on each accepted character, so characters may arrive back to back
// in_if.ready drops only while a result sits in the output register unread
// reset is synchronous and active low; cfg_if is always ready
`default_nettype none

module dos_short_name_formatter (
  input wire logic   clk,
  input wire logic   rst_n,
  dsnf_in_if.sink    in_if,
  dsnf_out_if.source out_if,
  dsnf_cfg_if.sink   cfg_if
);

  dsnf_pkg::cfg_t    cfg_r;
  logic              out_valid_r;
  dsnf_pkg::result_t out_res_r;
  logic              in_acc;
  logic              emit;
  dsnf_pkg::result_t result;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  dsnf_name u_name (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (in_acc),
    .char_code  (in_if.char_code),
    .last_char  (in_if.last_char),
    .name_empty (in_if.name_empty),
    .cfg        (cfg_r),
    .emit       (emit),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_mode     <= dsnf_pkg::MODE_NORMAL;
      cfg_r.allow_dot_dirs <= 1'b1;
    end else if (cfg_if.valid) begin
      unique case (dsnf_pkg::reg_idx_t'(cfg_if.index))
        dsnf_pkg::REG_CHECK_MODE:     cfg_r.check_mode <= dsnf_pkg::mode_t'(cfg_if.data);
        dsnf_pkg::REG_ALLOW_DOT_DIRS: cfg_r.allow_dot_dirs <= cfg_if.data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_res_r <= result;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_res_r.status;
  assign out_if.base_field = out_res_r.base_field;
  assign out_if.ext_field  = out_res_r.ext_field;

endmodule

`default_nettype wire

// ----- src/dsnf_name.sv -----
// per-name state, character checks and final result formation
`default_nettype none

module dsnf_name (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic [7:0]      char_code,
  input  wire logic            last_char,
  input  wire logic            name_empty,
  input  wire dsnf_pkg::cfg_t  cfg,
  output logic                 emit,
  output dsnf_pkg::result_t    result
);

  logic [7:0]       base_r [dsnf_pkg::BaseLen];
  logic [7:0]       base_nxt [dsnf_pkg::BaseLen];
  logic [7:0]       ext_r [dsnf_pkg::ExtLen];
  logic [7:0]       ext_nxt [dsnf_pkg::ExtLen];
  dsnf_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]       fill_r, fill_nxt;
  logic             lws_r, lws_nxt;
  logic             err_r, err_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             dots_r, dots_nxt;

  logic [7:0]       w_base [dsnf_pkg::BaseLen];
  logic [7:0]       w_ext [dsnf_pkg::ExtLen];
  dsnf_pkg::phase_t w_phase;
  logic [3:0]       w_fill;
  logic             w_lws;
  logic             w_err;
  logic [1:0]       w_cnt;
  logic             w_dots;
  logic             strict;
  logic             bad;
  logic             is_dot;
  logic             dot_name;
  logic             fin_err;
  logic             clear;
  logic [63:0]      base_flat;
  logic [23:0]      ext_flat;

  function automatic logic char_bad(input logic [7:0] c, input dsnf_pkg::mode_t mode);
    logic in_bad;
    logic in_strict;
    logic in_repl;
    logic upper;
    in_bad = (c == "*") || (c == "?") || (c == "<") || (c == ">") || (c == "|") ||
             (c == "\"") || (c == ":") || (c == "/") || (c == "\\");
    in_strict = (c == "+") || (c == "=") || (c == ",") || (c == ";") || (c == " ") ||
                (c == "[") || (c == "]");
    in_repl = (c == "[") || (c == "]") || (c == ";") || (c == ",") || (c == "+") ||
              (c == "=");
    upper = (c >= "A") && (c <= "Z");
    char_bad = (mode != dsnf_pkg::MODE_RELAXED && in_bad) ||
               (mode == dsnf_pkg::MODE_STRICT && in_strict) ||
               (mode == dsnf_pkg::MODE_STRICT_REPL && in_repl) ||
               ((mode == dsnf_pkg::MODE_STRICT || mode == dsnf_pkg::MODE_STRICT_REPL)
                && upper) ||
               (c < dsnf_pkg::CharSpace) || (c == ":") || (c == "\\");
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic is_device(input logic [63:0] b);
    logic tail3;
    logic tail4;
    logic three;
    logic four;
    tail3 = (b[39:0] == {5{dsnf_pkg::CharSpace}});
    tail4 = (b[31:0] == {4{dsnf_pkg::CharSpace}});
    three = (b[63:40] == "CON") || (b[63:40] == "PRN") || (b[63:40] == "NUL") ||
            (b[63:40] == "AUX");
    four  = ((b[63:40] == "LPT") || (b[63:40] == "COM")) &&
            (b[39:32] >= "1") && (b[39:32] <= "4");
    is_device = (tail3 && three) || (tail4 && four);
  endfunction

  always_comb begin
    w_base  = base_r;
    w_ext   = ext_r;
    w_phase = phase_r;
    w_fill  = fill_r;
    w_lws   = lws_r;
    w_err   = err_r;
    w_cnt   = cnt_r;
    w_dots  = dots_r;
    strict  = (cfg.check_mode == dsnf_pkg::MODE_STRICT) ||
              (cfg.check_mode == dsnf_pkg::MODE_STRICT_REPL);
    bad     = char_bad(char_code, cfg.check_mode);
    is_dot  = (char_code == dsnf_pkg::CharDot);

    if (cnt_r != 2'd3) begin
      w_cnt = cnt_r + 2'd1;
    end
    if (!is_dot) begin
      w_dots = 1'b0;
    end

    if (!err_r) begin
      unique case (phase_r)
        dsnf_pkg::PH_BASE: begin
          if (bad) begin
            w_err = 1'b1;
          end else if (is_dot) begin
            if (lws_r) begin
              w_err = 1'b1;
            end else begin
              w_phase = dsnf_pkg::PH_EXT;
              w_fill  = 4'(dsnf_pkg::BaseLen);
            end
          end else begin
            w_lws = (char_code == dsnf_pkg::CharSpace);
            w_base[fill_r[2:0]] = upcase(char_code);
            w_fill = fill_r + 4'd1;
            if (w_fill >= 4'(dsnf_pkg::BaseLen)) begin
              if (w_lws) begin
                w_err = 1'b1;
              end else begin
                w_phase = strict ? dsnf_pkg::PH_SDOT : dsnf_pkg::PH_SKIP;
              end
            end
          end
        end
        dsnf_pkg::PH_SKIP: begin
          if (is_dot) begin
            w_phase = dsnf_pkg::PH_EXT;
            w_fill  = 4'(dsnf_pkg::BaseLen);
          end
        end
        dsnf_pkg::PH_SDOT: begin
          if (is_dot) begin
            w_phase = dsnf_pkg::PH_EXT;
            w_fill  = 4'(dsnf_pkg::BaseLen);
          end else begin
            w_err = 1'b1;
          end
        end
        dsnf_pkg::PH_EXT: begin
          if (fill_r >= 4'(dsnf_pkg::NameLen) || fill_r < 4'(dsnf_pkg::BaseLen)) begin
            if (strict) begin
              w_err = 1'b1;
            end
          end else if (bad || is_dot) begin
            w_err = 1'b1;
          end else begin
            w_lws = (char_code == dsnf_pkg::CharSpace);
            // fill 8..10 maps to extension slot 0..2
            w_ext[fill_r[1:0]] = upcase(char_code);
            w_fill = fill_r + 4'd1;
          end
        end
      endcase
    end

    base_flat = {w_base[0], w_base[1], w_base[2], w_base[3],
                 w_base[4], w_base[5], w_base[6], w_base[7]};
    ext_flat  = {w_ext[0], w_ext[1], w_ext[2]};
    dot_name  = w_dots && (w_cnt == 2'd1 || w_cnt == 2'd2);
    fin_err   = w_err ||
                ((w_phase == dsnf_pkg::PH_BASE || w_phase == dsnf_pkg::PH_EXT) && w_lws) ||
                is_device(base_flat);

    emit              = name_empty || last_char;
    result.status     = dsnf_pkg::ST_VALID;
    result.base_field = '0;
    result.ext_field  = '0;
    if (name_empty) begin
      result.status = dsnf_pkg::ST_INVALID;
    end else if (last_char) begin
      if (dot_name) begin
        if (cfg.allow_dot_dirs) begin
          result.base_field = {dsnf_pkg::CharDot,
                               (w_cnt == 2'd2) ? dsnf_pkg::CharDot : dsnf_pkg::CharSpace,
                               {6{dsnf_pkg::CharSpace}}};
          result.ext_field  = {3{dsnf_pkg::CharSpace}};
        end else begin
          result.status = dsnf_pkg::ST_DOT_DENIED;
        end
      end else if (fin_err) begin
        result.status = dsnf_pkg::ST_INVALID;
      end else begin
        result.base_field = base_flat;
        result.ext_field  = ext_flat;
      end
    end

    // name finished or discarded: start the next one afresh
    clear = name_empty || last_char;
    for (int i = 0; i < dsnf_pkg::BaseLen; i++) begin
      base_nxt[i] = clear ? dsnf_pkg::CharSpace : w_base[i];
    end
    for (int i = 0; i < dsnf_pkg::ExtLen; i++) begin
      ext_nxt[i] = clear ? dsnf_pkg::CharSpace : w_ext[i];
    end
    phase_nxt = clear ? dsnf_pkg::PH_BASE : w_phase;
    fill_nxt  = clear ? 4'd0 : w_fill;
    lws_nxt   = clear ? 1'b1 : w_lws;
    err_nxt   = clear ? 1'b0 : w_err;
    cnt_nxt   = clear ? 2'd0 : w_cnt;
    dots_nxt  = clear ? 1'b1 : w_dots;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dsnf_pkg::BaseLen; i++) begin
        base_r[i] <= dsnf_pkg::CharSpace;
      end
      for (int i = 0; i < dsnf_pkg::ExtLen; i++) begin
        ext_r[i] <= dsnf_pkg::CharSpace;
      end
      phase_r <= dsnf_pkg::PH_BASE;
      fill_r  <= 4'd0;
      lws_r   <= 1'b1;
      err_r   <= 1'b0;
      cnt_r   <= 2'd0;
      dots_r  <= 1'b1;
    end else if (en) begin
      base_r  <= base_nxt;
      ext_r   <= ext_nxt;
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      lws_r   <= lws_nxt;
      err_r   <= err_nxt;
      cnt_r   <= cnt_nxt;
      dots_r  <= dots_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/dsnf_checker.sv -----
// port-level checks on the short name formatter, bound to the top level
`default_nettype none

module dsnf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last_char,
  input wire logic        in_name_empty,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [63:0] out_base_field,
  input wire logic [23:0] out_ext_field
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_base_field) && $stable(out_ext_field))
    else $error("stalled result changed");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc && (in_last_char || in_name_empty)))
    else $error("result without a finishing transaction");

  a_empty_name: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_name_empty |=> out_valid && out_status == dsnf_pkg::ST_INVALID)
    else $error("empty name not reported invalid");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dsnf_pkg::ST_VALID |-> out_base_field == '0 &&
      out_ext_field == '0)
    else $error("rejected name carries field data");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind dos_short_name_formatter dsnf_checker u_dsnf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .in_last_char   (in_if.last_char),
  .in_name_empty  (in_if.name_empty),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_status     (out_if.status),
  .out_base_field (out_if.base_field),
  .out_ext_field  (out_if.ext_field)
);

`default_nettype wire

// ----- sim/dos_short_name_formatter_test.sv -----
// self-checking testbench for the 8.3 short name formatter
module dos_short_name_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  class short_name_tracker;
    dsnf_pkg::mode_t   check_mode;
    logic              allow_dot_dirs;
    logic [7:0]        base_bytes [dsnf_pkg::BaseLen];
    logic [7:0]        ext_bytes [dsnf_pkg::ExtLen];
    dsnf_pkg::phase_t  phase;
    int unsigned       fill_count;
    int unsigned       char_count;
    bit                last_was_space;
    bit                error_seen;
    bit                only_dots;
    dsnf_pkg::result_t expected_names [$];
    int unsigned       mismatches;

    function new();
      check_mode     = dsnf_pkg::MODE_NORMAL;
      allow_dot_dirs = 1'b1;
      mismatches     = 0;
      clear_name();
    endfunction

    function void clear_name();
      foreach (base_bytes[i]) base_bytes[i] = dsnf_pkg::CharSpace;
      foreach (ext_bytes[i]) ext_bytes[i] = dsnf_pkg::CharSpace;
      phase          = dsnf_pkg::PH_BASE;
      fill_count     = 0;
      char_count     = 0;
      last_was_space = 1'b1;
      error_seen     = 1'b0;
      only_dots      = 1'b1;
    endfunction

    function void write_reg(logic idx, logic [1:0] value);
      if (idx == dsnf_pkg::REG_CHECK_MODE) begin
        check_mode = dsnf_pkg::mode_t'(value);
      end else begin
        allow_dot_dirs = value[0];
      end
    endfunction

    function bit is_strict();
      return check_mode == dsnf_pkg::MODE_STRICT || check_mode == dsnf_pkg::MODE_STRICT_REPL;
    endfunction

    function bit char_bad(logic [7:0] c);
      bit banned, strict_hit, repl_hit;
      case (c)
        "*", "?", "<", ">", "|", "\"", ":", "/", "\\": banned = 1'b1;
        default: banned = 1'b0;
      endcase
      case (c)
        "+", "=", ",", ";", " ", "[", "]": strict_hit = 1'b1;
        default: strict_hit = 1'b0;
      endcase
      case (c)
        "[", "]", ";", ",", "+", "=": repl_hit = 1'b1;
        default: repl_hit = 1'b0;
      endcase
      if (check_mode != dsnf_pkg::MODE_RELAXED && banned) return 1'b1;
      if (check_mode == dsnf_pkg::MODE_STRICT && strict_hit) return 1'b1;
      if (check_mode == dsnf_pkg::MODE_STRICT_REPL && repl_hit) return 1'b1;
      if (is_strict() && c >= "A" && c <= "Z") return 1'b1;
      if (c < 8'h20 || c == ":" || c == "\\") return 1'b1;
      return 1'b0;
    endfunction

    function logic [7:0] upcase(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function bit is_device();
      bit tail3, tail4;
      logic [23:0] head;
      tail3 = 1'b1;
      tail4 = 1'b1;
      for (int i = 3; i < dsnf_pkg::BaseLen; i++)
        if (base_bytes[i] != dsnf_pkg::CharSpace) tail3 = 1'b0;
      for (int i = 4; i < dsnf_pkg::BaseLen; i++)
        if (base_bytes[i] != dsnf_pkg::CharSpace) tail4 = 1'b0;
      head = {base_bytes[0], base_bytes[1], base_bytes[2]};
      if (tail3 && (head == "CON" || head == "PRN" || head == "NUL" || head == "AUX"))
        return 1'b1;
      if (tail4 && (head == "LPT" || head == "COM") &&
          base_bytes[3] >= "1" && base_bytes[3] <= "4")
        return 1'b1;
      return 1'b0;
    endfunction

    function void take_char(logic [7:0] c);
      if (char_count < 3) char_count++;
      if (c != dsnf_pkg::CharDot) only_dots = 1'b0;
      if (error_seen) return;
      case (phase)
        dsnf_pkg::PH_BASE: begin
          if (char_bad(c)) begin
            error_seen = 1'b1;
            return;
          end
          if (c == dsnf_pkg::CharDot) begin
            if (last_was_space) error_seen = 1'b1;
            else begin
              phase      = dsnf_pkg::PH_EXT;
              fill_count = dsnf_pkg::BaseLen;
            end
            return;
          end
          last_was_space = (c == dsnf_pkg::CharSpace);
          base_bytes[fill_count % dsnf_pkg::BaseLen] = upcase(c);
          fill_count++;
          if (fill_count >= dsnf_pkg::BaseLen) begin
            if (last_was_space) error_seen = 1'b1;
            else phase = is_strict() ? dsnf_pkg::PH_SDOT : dsnf_pkg::PH_SKIP;
          end
        end
        dsnf_pkg::PH_SKIP: begin
          if (c == dsnf_pkg::CharDot) begin
            phase      = dsnf_pkg::PH_EXT;
            fill_count = dsnf_pkg::BaseLen;
          end
        end
        dsnf_pkg::PH_SDOT: begin
          if (c == dsnf_pkg::CharDot) begin
            phase      = dsnf_pkg::PH_EXT;
            fill_count = dsnf_pkg::BaseLen;
          end else begin
            error_seen = 1'b1;
          end
        end
        default: begin
          if (fill_count >= dsnf_pkg::NameLen || fill_count < dsnf_pkg::BaseLen) begin
            if (is_strict()) error_seen = 1'b1;
            return;
          end
          if (char_bad(c) || c == dsnf_pkg::CharDot) begin
            error_seen = 1'b1;
            return;
          end
          last_was_space = (c == dsnf_pkg::CharSpace);
          ext_bytes[(fill_count - dsnf_pkg::BaseLen) % dsnf_pkg::ExtLen] = upcase(c);
          fill_count++;
        end
      endcase
    endfunction

    function void accept_char(logic [7:0] c, logic last, logic empty);
      dsnf_pkg::result_t r;
      r.status     = dsnf_pkg::ST_INVALID;
      r.base_field = '0;
      r.ext_field  = '0;
      if (empty) begin
        clear_name();
        expected_names.push_back(r);
        return;
      end
      take_char(c);
      if (!last) return;
      if (only_dots && (char_count == 1 || char_count == 2)) begin
        if (allow_dot_dirs) begin
          foreach (base_bytes[i]) base_bytes[i] = dsnf_pkg::CharSpace;
          foreach (ext_bytes[i]) ext_bytes[i] = dsnf_pkg::CharSpace;
          base_bytes[0] = dsnf_pkg::CharDot;
          if (char_count == 2) base_bytes[1] = dsnf_pkg::CharDot;
          r.status = dsnf_pkg::ST_VALID;
        end else begin
          r.status = dsnf_pkg::ST_DOT_DENIED;
        end
      end else begin
        if (!error_seen && last_was_space &&
            (phase == dsnf_pkg::PH_BASE || phase == dsnf_pkg::PH_EXT))
          error_seen = 1'b1;
        if (!error_seen && is_device()) error_seen = 1'b1;
        if (error_seen) r.status = dsnf_pkg::ST_INVALID;
        else r.status = dsnf_pkg::ST_VALID;
      end
      if (r.status == dsnf_pkg::ST_VALID) begin
        foreach (base_bytes[i]) r.base_field = {r.base_field[55:0], base_bytes[i]};
        foreach (ext_bytes[i]) r.ext_field = {r.ext_field[15:0], ext_bytes[i]};
      end
      expected_names.push_back(r);
      clear_name();
    endfunction

    function void check_name(logic [1:0] status, logic [63:0] base_field,
                             logic [23:0] ext_field);
      dsnf_pkg::result_t want;
      if (expected_names.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d base %h ext %h",
                 $time, status, base_field, ext_field);
        mismatches++;
        return;
      end
      want = expected_names.pop_front();
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        mismatches++;
      end
      if (base_field !== want.base_field) begin
        $display("%0t: base expected %h actual %h", $time, want.base_field, base_field);
        mismatches++;
      end
      if (ext_field !== want.ext_field) begin
        $display("%0t: ext expected %h actual %h", $time, want.ext_field, ext_field);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_names.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dsnf_in_if  in_ch ();
  dsnf_out_if out_ch ();
  dsnf_cfg_if cfg_ch ();

  dos_short_name_formatter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  short_name_tracker names = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned items_sent     = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      names.accept_char(in_ch.char_code, in_ch.last_char, in_ch.name_empty);
    if (rst_n && out_ch.valid && out_ch.ready)
      names.check_name(out_ch.status, out_ch.base_field, out_ch.ext_field);
    if (rst_n && cfg_ch.valid && cfg_ch.ready)
      names.write_reg(cfg_ch.index, cfg_ch.data);
  end

  task automatic send_item(input logic [7:0] c, input logic last, input logic empty);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.char_code  <= c;
    in_ch.last_char  <= last;
    in_ch.name_empty <= empty;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1, 1'b0);
  endtask

  task automatic configure(input dsnf_pkg::mode_t mode, input logic allow);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= dsnf_pkg::REG_CHECK_MODE;
    cfg_ch.data  <= mode;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= dsnf_pkg::REG_ALLOW_DOT_DIRS;
    cfg_ch.data  <= {1'($urandom_range(1)), allow};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (names.pending() != 0 || out_ch.valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    string specials = "*?<>|\":/\\+=,; []";
    string plain    = "-_~!.$#";
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return "a" + 8'($urandom_range(25));
    if (roll < 65) return "0" + 8'($urandom_range(9));
    if (roll < 73) return "A" + 8'($urandom_range(25));
    if (roll < 81) return specials[$urandom_range(specials.len() - 1)];
    if (roll < 87) return 8'h80 + 8'($urandom_range(127));
    if (roll < 92) return dsnf_pkg::CharSpace;
    if (roll < 94) return 8'($urandom_range(31));
    return plain[$urandom_range(plain.len() - 1)];
  endfunction

  task automatic send_random_name();
    logic [7:0] chars [$];
    string word;
    int unsigned kind, base_len, ext_len;
    kind = $urandom_range(99);
    if (kind < 55) begin
      base_len = ($urandom_range(4) == 0) ? $urandom_range(11, 9) : $urandom_range(8, 1);
      repeat (base_len) chars.push_back(pick_char());
      if ($urandom_range(9) == 0) chars[chars.size() - 1] = dsnf_pkg::CharSpace;
      if ($urandom_range(9) < 7) begin
        chars.push_back(dsnf_pkg::CharDot);
        ext_len = ($urandom_range(5) == 0) ? $urandom_range(5, 4) : $urandom_range(3, 0);
        repeat (ext_len) chars.push_back(pick_char());
        if (ext_len > 0 && $urandom_range(9) == 0)
          chars[chars.size() - 1] = dsnf_pkg::CharSpace;
      end
    end else if (kind < 67) begin
      case ($urandom_range(7))
        0: word = "con";
        1: word = "prn";
        2: word = "nul";
        3: word = "aux";
        4: word = "lpt";
        5: word = "com";
        6: word = "CON";
        default: word = "Aux";
      endcase
      for (int i = 0; i < word.len(); i++) chars.push_back(word[i]);
      if ($urandom_range(2) != 0) chars.push_back("0" + 8'($urandom_range(5)));
      if ($urandom_range(2) == 0) begin
        chars.push_back(dsnf_pkg::CharDot);
        repeat ($urandom_range(3, 1)) chars.push_back(pick_char());
      end
    end else if (kind < 77) begin
      repeat ($urandom_range(3, 1)) chars.push_back(dsnf_pkg::CharDot);
      if ($urandom_range(3) == 0) chars.push_back(pick_char());
    end else if (kind < 92) begin
      repeat ($urandom_range(14, 1)) chars.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3)) send_item(pick_char(), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      return;
    end
    foreach (chars[i]) send_item(chars[i], i == chars.size() - 1, 1'b0);
  endtask

  initial begin
    int unsigned target;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_code  = 8'h00;
    in_ch.last_char  = 1'b0;
    in_ch.name_empty = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = dsnf_pkg::REG_CHECK_MODE;
    cfg_ch.data      = 2'b00;
    out_ch.ready     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_text(".");
    send_text("..");
    send_item(8'hff, 1'b1, 1'b1);
    send_text("con");
    send_text("lpt1");
    send_text(".x");
    send_text("a ");
    send_text("ab.c.");
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    in_ch.valid <= 1'b0;
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      for (int m = 0; m < 4; m++) begin
        configure(dsnf_pkg::mode_t'(m), 1'((m ^ p) & 1));
        // long receiver hold-off so the block backs up onto its input
        if (p == 0 && m == 1) hold_left = 400;
        target = items_sent + 40;
        while (items_sent < target) send_random_name();
        in_ch.valid <= 1'b0;
        drain();
      end
    end

    repeat (8) @(posedge clk);
    if (names.mismatches == 0 && names.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
